// File: sv/cdg_pkg.sv
`default_nettype none
package cdg_pkg;

  localparam int FrameWidth  = 300;
  localparam int FrameHeight = 216;
  localparam int FramePixels = FrameWidth * FrameHeight;
  localparam int AddrW       = $clog2(FramePixels);
  localparam int XW          = $clog2(FrameWidth);
  localparam int YW          = $clog2(FrameHeight);

  localparam int TileW       = 6;
  localparam int TileH       = 12;
  // tile origin reaches 63*6 columns and 31*12 rows
  localparam int TileXW      = $clog2(64 * TileW);
  localparam int TileYW      = $clog2(32 * TileH);

  localparam logic [5:0] CMD_GRAPHICS = 6'h09;

  typedef enum logic [5:0] {
    INS_MEM_PRESET    = 6'd1,
    INS_BORDER        = 6'd2,
    INS_TILE          = 6'd6,
    INS_SCROLL_PRESET = 6'd20,
    INS_SCROLL_COPY   = 6'd24,
    INS_TRANSPARENT   = 6'd28,
    INS_PAL_LO        = 6'd30,
    INS_PAL_HI        = 6'd31,
    INS_TILE_XOR      = 6'd38
  } instr_t;

  localparam logic [1:0] SCR_FWD  = 2'd1;
  localparam logic [1:0] SCR_BACK = 2'd2;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_CLEAR,
    ST_TILE_RD,
    ST_TILE_WR,
    ST_SCROLL,
    ST_SCROLL_END,
    ST_READ
  } state_t;

  function automatic logic [7:0] pkt_byte(input logic [127:0] data, input logic [3:0] k);
    pkt_byte = data[k*8 +: 8];
  endfunction

  function automatic logic [7:0] scale17(input logic [3:0] v);
    scale17 = {v, v};
  endfunction

  function automatic logic [23:0] pal_entry(input logic [7:0] b0, input logic [7:0] b1);
    logic [3:0] r;
    logic [3:0] g;
    logic [3:0] b;
    r = b0[5:2];
    g = {b0[1:0], b1[5:4]};
    b = b1[3:0];
    pal_entry = {scale17(r), scale17(g), scale17(b)};
  endfunction

endpackage
`default_nettype wire

// File: sv/cdg_if.sv
`default_nettype none
interface cdg_pkt_if;
  logic        valid;
  logic        ready;
  logic        operation;
  logic [5:0]  command_code;
  logic [5:0]  instruction_code;
  logic [63:0] data_low;
  logic [63:0] data_high;
  logic [8:0]  read_x;
  logic [7:0]  read_y;

  modport source (output valid, operation, command_code, instruction_code, data_low,
                  data_high, read_x, read_y, input ready);
  modport sink (input valid, operation, command_code, instruction_code, data_low,
                data_high, read_x, read_y, output ready);
endinterface

interface cdg_res_if;
  logic        valid;
  logic        ready;
  logic [3:0]  pixel_index;
  logic [23:0] pixel_rgb;
  logic [3:0]  border_index;
  logic [3:0]  transparent_index;

  modport source (output valid, pixel_index, pixel_rgb, border_index, transparent_index,
                  input ready);
  modport sink (input valid, pixel_index, pixel_rgb, border_index, transparent_index,
                output ready);
endinterface
`default_nettype wire

// File: sv/cdg_packet_renderer.sv
// cdg_packet_renderer: cd+g graphics decoder holding an indexed frame and palette
//
// pkt channel: one beat carries either a subchannel packet (operation 0) or a
// pixel read request (operation 1). res channel: one beat per pixel read, with
// the stored index, its palette rgb and the border and transparent registers.
// Packets give no result beat.
// The frame lives in two single-write, registered-read memory banks; scroll
// reads the live bank and writes the other, then swaps them.
// Register and palette packets are done when accepted; a pixel read passes
// through ST_READ, which registers the bank's read data as the result; a tile
// reads then writes each pixel; memory preset writes one pixel per cycle; scroll
// copies one pixel per cycle and then swaps the banks in ST_SCROLL_END.
// This pace is set by the single write port of each frame bank.
// A new beat is taken only when the sequencer is idle and the result register
// is empty or being drained; a stalled receiver holds the result and blocks
// further beats.
// Reset (rst, synchronous) clears the palette and colour registers and runs a
// clearing pass over the frame, during which pkt is not ready.
`default_nettype none
module cdg_packet_renderer (
  input wire logic   clk,
  input wire logic   rst,
  cdg_pkt_if.sink    pkt,
  cdg_res_if.source  res
);
  import cdg_pkg::*;

  state_t state;
  state_t state_next;

  logic bank;
  logic [3:0] fill;
  logic [AddrW-1:0] dst;

  logic [23:0] palette [16];
  logic [3:0] border;
  logic [3:0] transparent;

  logic out_valid;
  logic [3:0] out_index;
  logic [23:0] out_rgb;
  logic [3:0] out_border;
  logic [3:0] out_transparent;

  // tile
  logic [95:0] tile_rows;
  logic [3:0] tile_c0;
  logic [3:0] tile_c1;
  logic tile_xor;
  logic [TileYW-1:0] tile_top;
  logic [TileXW-1:0] tile_left;
  logic [3:0] tile_r;
  logic [2:0] tile_c;

  // scroll
  logic [1:0] hmode;
  logic [1:0] vmode;
  logic wrap;
  logic [XW-1:0] sx;
  logic [XW-1:0] sx0;
  logic [YW-1:0] sy;
  logic [XW-1:0] x;
  logic [YW-1:0] y;
  logic [AddrW-1:0] src_base;
  logic p_valid;
  logic [AddrW-1:0] p_addr;
  logic p_fill;

  logic accept;
  logic [127:0] pdata;
  logic [7:0] pb0;
  logic [7:0] pb1;
  logic [7:0] pb2;
  logic [7:0] pb3;
  logic [1:0] hcmd;
  logic [1:0] vcmd;
  logic scroll_moves;
  logic is_gfx;

  logic [XW-1:0] rx;
  logic [YW-1:0] ry;
  logic [AddrW-1:0] read_addr;

  logic [TileYW-1:0] py;
  logic [TileXW-1:0] px;
  logic tile_in;
  logic [AddrW-1:0] tile_addr;
  logic [7:0] tile_row;
  logic [3:0] tile_col;
  logic tile_last;

  logic hout;
  logic vout;

  logic we_cur;
  logic we_oth;
  logic [AddrW-1:0] waddr;
  logic [3:0] wdata;
  logic [AddrW-1:0] raddr;
  logic [3:0] rd0;
  logic [3:0] rd1;
  logic [3:0] rdata;

  assign pkt.ready = (state == ST_IDLE) && (!out_valid || res.ready);
  assign accept    = pkt.valid && pkt.ready;
  assign pdata     = {pkt.data_high, pkt.data_low};
  assign pb0       = pkt_byte(pdata, 4'd0);
  assign pb1       = pkt_byte(pdata, 4'd1);
  assign pb2       = pkt_byte(pdata, 4'd2);
  assign pb3       = pkt_byte(pdata, 4'd3);
  assign hcmd      = pb1[5:4];
  assign vcmd      = pb2[5:4];
  assign scroll_moves = (hcmd == SCR_FWD) || (hcmd == SCR_BACK) ||
                        (vcmd == SCR_FWD) || (vcmd == SCR_BACK);
  assign is_gfx    = !pkt.operation && (pkt.command_code == CMD_GRAPHICS);

  assign res.valid             = out_valid;
  assign res.pixel_index       = out_index;
  assign res.pixel_rgb         = out_rgb;
  assign res.border_index      = out_border;
  assign res.transparent_index = out_transparent;

  // pixel read address with saturation
  always_comb begin
    if (32'(pkt.read_x) >= FrameWidth) begin
      rx = XW'(FrameWidth - 1);
    end else begin
      rx = XW'(pkt.read_x);
    end
    if (32'(pkt.read_y) >= FrameHeight) begin
      ry = YW'(FrameHeight - 1);
    end else begin
      ry = YW'(pkt.read_y);
    end
    read_addr = AddrW'(32'(ry) * FrameWidth + 32'(rx));
  end

  // tile pixel position
  assign py        = tile_top + TileYW'(tile_r);
  assign px        = tile_left + TileXW'(tile_c);
  assign tile_in   = (32'(py) < FrameHeight) && (32'(px) < FrameWidth);
  assign tile_addr = tile_in ? AddrW'(32'(py) * FrameWidth + 32'(px)) : '0;
  assign tile_row  = tile_rows[tile_r*8 +: 8];
  assign tile_col  = tile_row[3'd5 - tile_c] ? tile_c1 : tile_c0;
  assign tile_last = (32'(tile_r) == TileH - 1) && (32'(tile_c) == TileW - 1);

  // exposed area for scroll preset
  assign hout = ((hmode == SCR_FWD) && (32'(x) < TileW)) ||
                ((hmode == SCR_BACK) && (32'(x) >= FrameWidth - TileW));
  assign vout = ((vmode == SCR_FWD) && (32'(y) < TileH)) ||
                ((vmode == SCR_BACK) && (32'(y) >= FrameHeight - TileH));

  assign rdata = bank ? rd1 : rd0;

  // memory port steering
  always_comb begin
    we_cur = 1'b0;
    we_oth = 1'b0;
    waddr  = dst;
    wdata  = fill;
    raddr  = read_addr;
    case (state)
      ST_CLEAR: begin
        we_cur = 1'b1;
      end
      ST_TILE_RD: begin
        raddr = tile_addr;
      end
      ST_TILE_WR: begin
        we_cur = tile_in;
        waddr  = tile_addr;
        wdata  = tile_xor ? (rdata ^ tile_col) : tile_col;
      end
      ST_SCROLL, ST_SCROLL_END: begin
        raddr  = src_base + AddrW'(sx);
        we_oth = p_valid;
        waddr  = p_addr;
        wdata  = p_fill ? fill : rdata;
      end
      default: begin
      end
    endcase
  end

  cdg_ram #(.Depth(FramePixels), .Width(4)) u_bank0 (
    .clk   (clk),
    .we    ((we_cur && !bank) || (we_oth && bank)),
    .waddr (waddr),
    .wdata (wdata),
    .raddr (raddr),
    .rdata (rd0)
  );

  cdg_ram #(.Depth(FramePixels), .Width(4)) u_bank1 (
    .clk   (clk),
    .we    ((we_cur && bank) || (we_oth && !bank)),
    .waddr (waddr),
    .wdata (wdata),
    .raddr (raddr),
    .rdata (rd1)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= ST_CLEAR;
    end else begin
      state <= state_next;
    end
  end

  always_comb begin
    state_next = state;
    case (state)
      ST_IDLE: begin
        if (accept) begin
          if (pkt.operation) begin
            state_next = ST_READ;
          end else if (is_gfx) begin
            case (instr_t'(pkt.instruction_code))
              INS_MEM_PRESET: state_next = ST_CLEAR;
              INS_TILE, INS_TILE_XOR: state_next = ST_TILE_RD;
              INS_SCROLL_PRESET, INS_SCROLL_COPY: begin
                if (scroll_moves) begin
                  state_next = ST_SCROLL;
                end
              end
              default: state_next = ST_IDLE;
            endcase
          end
        end
      end
      ST_CLEAR: begin
        if (32'(dst) == FramePixels - 1) begin
          state_next = ST_IDLE;
        end
      end
      ST_TILE_RD: state_next = ST_TILE_WR;
      ST_TILE_WR: state_next = tile_last ? ST_IDLE : ST_TILE_RD;
      ST_SCROLL: begin
        if (32'(dst) == FramePixels - 1) begin
          state_next = ST_SCROLL_END;
        end
      end
      ST_SCROLL_END: state_next = ST_IDLE;
      ST_READ: state_next = ST_IDLE;
      default: state_next = ST_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      bank        <= 1'b0;
      fill        <= '0;
      dst         <= '0;
      border      <= '0;
      transparent <= '0;
      out_valid   <= 1'b0;
      p_valid     <= 1'b0;
      for (int i = 0; i < 16; i++) begin
        palette[i] <= '0;
      end
    end else begin
      if (out_valid && res.ready) begin
        out_valid <= 1'b0;
      end
      case (state)
        ST_IDLE: begin
          if (accept && is_gfx) begin
            dst <= '0;
            case (instr_t'(pkt.instruction_code))
              INS_MEM_PRESET: fill <= pb0[3:0];
              INS_BORDER: border <= pb0[3:0];
              INS_TRANSPARENT: transparent <= pb0[3:0];
              INS_PAL_LO, INS_PAL_HI: begin
                for (int i = 0; i < 8; i++) begin
                  palette[{pkt.instruction_code == INS_PAL_HI, 3'(i)}] <=
                    pal_entry(pkt_byte(pdata, 4'(2 * i)), pkt_byte(pdata, 4'(2 * i + 1)));
                end
              end
              INS_TILE, INS_TILE_XOR: begin
                tile_c0   <= pb0[3:0];
                tile_c1   <= pb1[3:0];
                tile_xor  <= (pkt.instruction_code == INS_TILE_XOR);
                tile_top  <= TileYW'(32'(pb2[4:0]) * TileH);
                tile_left <= TileXW'(32'(pb3[5:0]) * TileW);
                tile_rows <= pdata[127:32];
                tile_r    <= '0;
                tile_c    <= '0;
              end
              INS_SCROLL_PRESET, INS_SCROLL_COPY: begin
                fill  <= pb0[3:0];
                hmode <= hcmd;
                vmode <= vcmd;
                wrap  <= (pkt.instruction_code == INS_SCROLL_COPY);
                x     <= '0;
                y     <= '0;
                if (hcmd == SCR_FWD) begin
                  sx  <= XW'(FrameWidth - TileW);
                  sx0 <= XW'(FrameWidth - TileW);
                end else if (hcmd == SCR_BACK) begin
                  sx  <= XW'(TileW);
                  sx0 <= XW'(TileW);
                end else begin
                  sx  <= '0;
                  sx0 <= '0;
                end
                if (vcmd == SCR_FWD) begin
                  sy       <= YW'(FrameHeight - TileH);
                  src_base <= AddrW'((FrameHeight - TileH) * FrameWidth);
                end else if (vcmd == SCR_BACK) begin
                  sy       <= YW'(TileH);
                  src_base <= AddrW'(TileH * FrameWidth);
                end else begin
                  sy       <= '0;
                  src_base <= '0;
                end
              end
              default: begin
              end
            endcase
          end
        end
        ST_CLEAR: begin
          dst <= dst + 1'b1;
        end
        ST_TILE_WR: begin
          if (32'(tile_c) == TileW - 1) begin
            tile_c <= '0;
            tile_r <= tile_r + 1'b1;
          end else begin
            tile_c <= tile_c + 1'b1;
          end
        end
        ST_SCROLL: begin
          p_valid <= 1'b1;
          p_addr  <= dst;
          p_fill  <= !wrap && (hout || vout);
          dst     <= dst + 1'b1;
          if (32'(x) == FrameWidth - 1) begin
            x  <= '0;
            sx <= sx0;
            y  <= y + 1'b1;
            if (32'(sy) == FrameHeight - 1) begin
              sy       <= '0;
              src_base <= '0;
            end else begin
              sy       <= sy + 1'b1;
              src_base <= src_base + AddrW'(FrameWidth);
            end
          end else begin
            x <= x + 1'b1;
            if (32'(sx) == FrameWidth - 1) begin
              sx <= '0;
            end else begin
              sx <= sx + 1'b1;
            end
          end
        end
        ST_SCROLL_END: begin
          p_valid <= 1'b0;
          bank    <= !bank;
        end
        ST_READ: begin
          out_valid       <= 1'b1;
          out_index       <= rdata;
          out_rgb         <= palette[rdata];
          out_border      <= border;
          out_transparent <= transparent;
        end
        default: begin
        end
      endcase
    end
  end

endmodule
`default_nettype wire

// File: sv/cdg_ram.sv
`default_nettype none
module cdg_ram #(
  parameter int Depth = 1024,
  parameter int Width = 4
) (
  input  wire logic                     clk,
  input  wire logic                     we,
  input  wire logic [$clog2(Depth)-1:0] waddr,
  input  wire logic [Width-1:0]         wdata,
  input  wire logic [$clog2(Depth)-1:0] raddr,
  output logic      [Width-1:0]         rdata
);

  logic [Width-1:0] mem [Depth];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
  end

  always_ff @(posedge clk) begin
    rdata <= mem[raddr];
  end

endmodule
`default_nettype wire
